@@ src/dcc_pkg.sv @@
// ----------------------------------------------------------------------------
// dcc_pkg: shared types and constants of the directory coherence controller
// Holds the directory state codes, command and message codes, the back end
// sequencer states and the queue status bundle.
// ----------------------------------------------------------------------------
package dcc_pkg;

  // Request commands.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Message kinds.
  localparam logic MSG_FETCH = 1'b0;
  localparam logic MSG_INVAL = 1'b1;

  // At most this many messages leave for one request.
  localparam int MAX_MSGS = 4;
  localparam int CNT_W    = $clog2(MAX_MSGS);
  localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(MAX_MSGS - 1);

  // Directory line state as stored in the entry.
  typedef enum logic [1:0] {
    DS_INVALID = 2'd0,
    DS_SHARED  = 2'd1,
    DS_EXCL    = 2'd2
  } dir_state_t;

  // Back end sequencer.
  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_PLAN  = 4'b0100,
    S_EMIT  = 4'b1000
  } back_state_t;

  // Status of the request queue.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ src/dcc_front.sv @@
// ----------------------------------------------------------------------------
// dcc_front: request intake
// Registers each incoming request, checks that home node and requester are
// real nodes, drops requests that are not, and hands the rest to the queue.
// ----------------------------------------------------------------------------
module dcc_front #(
  parameter int NODES     = 4,
  parameter int ADDR_BITS = 10,
  parameter int REQ_W     = ADDR_BITS + 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_command,
  input  logic [ADDR_BITS-1:0]   in_line_addr,
  input  logic [1:0]             in_home_node,
  input  logic [1:0]             in_requester,
  input  logic                   clr_busy,
  input  dcc_pkg::fifo_stat_t    fifo_stat,
  output logic                   push,
  output logic [REQ_W-1:0]       push_data
);
  import dcc_pkg::*;

  logic             front_v_r, front_v_nxt;
  logic             front_ok_r;
  logic [REQ_W-1:0] front_data_r;
  logic             drain;
  logic             accept;
  logic             in_range;

  assign in_range = (int'(in_home_node) < NODES) && (int'(in_requester) < NODES);

  // An out of range request leaves the stage without reaching the queue.
  assign drain    = front_v_r && (!front_ok_r || !fifo_stat.full);
  assign push     = front_v_r && front_ok_r && !fifo_stat.full;
  assign in_stall = clr_busy || (front_v_r && !drain);
  assign accept   = in_valid && !in_stall;

  assign push_data = front_data_r;

  always_comb begin
    front_v_nxt = front_v_r;
    if (accept) begin
      front_v_nxt = 1'b1;
    end else if (drain) begin
      front_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_ok_r   <= in_range;
      front_data_r <= {in_command, in_line_addr, in_home_node, in_requester};
    end
  end

endmodule

@@ src/dcc_fifo.sv @@
// ----------------------------------------------------------------------------
// dcc_fifo: request queue
// Short first-in first-out queue between the intake and the directory
// sequencer, so that either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module dcc_fifo #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    pop_data,
  output dcc_pkg::fifo_stat_t stat
);
  import dcc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;

  assign stat.full  = (count_r == (PTR_W + 1)'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_data   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ src/dcc_back.sv @@
// ----------------------------------------------------------------------------
// dcc_back: directory sequencer
// Owns the directory memory. Reads the entry of each queued request, plans
// its fetch and invalidate messages, writes the next entry back and sends the
// messages through a registered output stage, one per cycle unless out_stall holds it.
// ----------------------------------------------------------------------------
module dcc_back #(
  parameter int NODES     = 4,
  parameter int ADDR_BITS = 10,
  parameter int REQ_W     = ADDR_BITS + 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dcc_pkg::fifo_stat_t    fifo_stat,
  input  logic [REQ_W-1:0]       fifo_head,
  output logic                   fifo_pop,
  output logic                   clr_busy,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_msg_kind,
  output logic [1:0]             out_dest_node,
  output logic [1:0]             out_source_node,
  output logic [1:0]             out_reply_node,
  output logic [ADDR_BITS-1:0]   out_msg_addr,
  output logic                   out_is_local,
  output logic                   out_last
);
  import dcc_pkg::*;

  localparam int NODE_W = $clog2(NODES);
  localparam int IDX_W  = NODE_W + ADDR_BITS;
  localparam int ENT_W  = NODES + 2;
  localparam int DEPTH  = 1 << IDX_W;

  function automatic logic [NODE_W-1:0] lowest_idx(input logic [NODES-1:0] m);
    logic [NODE_W-1:0] r;
    r = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = NODE_W'(i);
      end
    end
    return r;
  endfunction

  // Directory memory: {sharers, state} per (home node, line).
  logic [ENT_W-1:0] dir_mem [DEPTH];
  logic [ENT_W-1:0] rd_data_r;

  back_state_t      state_r, state_nxt;
  logic [IDX_W:0]   clr_cnt_r, clr_cnt_nxt;

  logic                 cur_cmd_r;
  logic [ADDR_BITS-1:0] cur_addr_r;
  logic [1:0]           cur_home_r;
  logic [1:0]           cur_req_r;

  logic              fetch_pend_r, fetch_pend_nxt;
  logic [NODE_W-1:0] fetch_dest_r, fetch_dest_nxt;
  logic [NODES-1:0]  inv_mask_r, inv_mask_nxt;
  logic [CNT_W-1:0]  msg_cnt_r, msg_cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r;
  logic [1:0]           out_dest_r;
  logic [1:0]           out_src_r;
  logic [1:0]           out_reply_r;
  logic [ADDR_BITS-1:0] out_addr_r;
  logic                 out_local_r;
  logic                 out_last_r;

  // Queue head fields.
  logic                 hd_cmd;
  logic [ADDR_BITS-1:0] hd_addr;
  logic [1:0]           hd_home;
  logic [1:0]           hd_req;
  logic [IDX_W-1:0]     hd_idx;
  logic [IDX_W-1:0]     cur_idx;

  // Planning.
  dir_state_t        cur_st;
  logic [NODES-1:0]  cur_sh;
  logic [NODE_W-1:0] req_n;
  logic [NODE_W-1:0] home_n;
  logic [NODES-1:0]  req_bit;
  logic [NODES-1:0]  others;
  logic [NODES-1:0]  o_bit;
  logic [NODE_W-1:0] o_idx;
  logic              has_o;
  logic              pl_fetch;
  logic [NODE_W-1:0] pl_dest;
  logic [NODES-1:0]  pl_mask;
  dir_state_t        pl_st;
  logic [NODES-1:0]  pl_sh;
  logic              pl_any;

  // Emission.
  logic [NODE_W-1:0] inv_idx;
  logic [NODES-1:0]  inv_low;
  logic [NODES-1:0]  mask_after;
  logic              em_kind;
  logic [NODE_W-1:0] em_dest;
  logic              em_more;
  logic              out_free;
  logic              emit_fire;

  // Memory port control.
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [ENT_W-1:0]  mem_wd;
  logic              mem_re;

  assign hd_cmd  = fifo_head[REQ_W-1];
  assign hd_addr = fifo_head[REQ_W-2 -: ADDR_BITS];
  assign hd_home = fifo_head[3:2];
  assign hd_req  = fifo_head[1:0];
  assign hd_idx  = {NODE_W'(hd_home), hd_addr};
  assign cur_idx = {NODE_W'(cur_home_r), cur_addr_r};

  assign clr_busy = (state_r == S_CLEAR);
  assign fifo_pop = (state_r == S_IDLE) && !fifo_stat.empty;
  assign mem_re   = fifo_pop;

  // ---------------- planning from the entry just read ----------------
  assign cur_st  = dir_state_t'(rd_data_r[1:0]);
  assign cur_sh  = rd_data_r[ENT_W-1:2];
  assign req_n   = NODE_W'(cur_req_r);
  assign home_n  = NODE_W'(cur_home_r);
  assign req_bit = {{(NODES-1){1'b0}}, 1'b1} << req_n;
  assign others  = cur_sh & ~req_bit;
  assign has_o   = |others;
  assign o_bit   = others & (~others + {{(NODES-1){1'b0}}, 1'b1});
  assign o_idx   = lowest_idx(others);

  always_comb begin
    pl_fetch = 1'b0;
    pl_dest  = o_idx;
    pl_mask  = '0;
    pl_st    = cur_st;
    pl_sh    = cur_sh | req_bit;
    unique case (cur_st)
      DS_EXCL: begin
        pl_fetch = has_o;
        if (cur_cmd_r == CMD_READ) begin
          pl_st = DS_SHARED;
        end else begin
          // The previous owner is fetched and then invalidated.
          pl_mask = o_bit;
          pl_sh   = (cur_sh & ~o_bit) | req_bit;
        end
      end
      DS_SHARED: begin
        pl_fetch = has_o;
        if (cur_cmd_r == CMD_WRITE) begin
          pl_mask = others;
          pl_sh   = (cur_sh & ~others) | req_bit;
          pl_st   = DS_EXCL;
        end
      end
      default: begin
        // Invalid line: the home node's own cache supplies the data.
        pl_fetch = 1'b1;
        pl_dest  = home_n;
        pl_st    = (cur_cmd_r == CMD_WRITE) ? DS_EXCL : DS_SHARED;
      end
    endcase
  end

  assign pl_any = pl_fetch || (|pl_mask);

  // ---------------- message emission ----------------
  assign inv_idx    = lowest_idx(inv_mask_r);
  assign inv_low    = inv_mask_r & (~inv_mask_r + {{(NODES-1){1'b0}}, 1'b1});
  assign mask_after = fetch_pend_r ? inv_mask_r : (inv_mask_r & ~inv_low);
  assign em_kind    = fetch_pend_r ? MSG_FETCH : MSG_INVAL;
  assign em_dest    = fetch_pend_r ? fetch_dest_r : inv_idx;
  // Invalidates past the message cap are dropped; their bits are already cleared.
  assign em_more    = (|mask_after) && (msg_cnt_r != LAST_SLOT);
  assign out_free   = !out_valid_r || !out_stall;
  assign emit_fire  = (state_r == S_EMIT) && out_free;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    fetch_pend_nxt = fetch_pend_r;
    fetch_dest_nxt = fetch_dest_r;
    inv_mask_nxt   = inv_mask_r;
    msg_cnt_nxt    = msg_cnt_r;
    mem_we         = 1'b0;
    mem_wa         = cur_idx;
    mem_wd         = {pl_sh, pl_st};
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r[IDX_W]) begin
          state_nxt = S_IDLE;
        end else begin
          mem_we      = 1'b1;
          mem_wa      = clr_cnt_r[IDX_W-1:0];
          mem_wd      = '0;
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (fifo_pop) begin
          state_nxt = S_PLAN;
        end
      end
      S_PLAN: begin
        mem_we         = 1'b1;
        fetch_pend_nxt = pl_fetch;
        fetch_dest_nxt = pl_dest;
        inv_mask_nxt   = pl_mask;
        msg_cnt_nxt    = '0;
        state_nxt      = pl_any ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (emit_fire) begin
          fetch_pend_nxt = 1'b0;
          inv_mask_nxt   = mask_after;
          msg_cnt_nxt    = msg_cnt_r + 1'b1;
          if (!em_more) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      fetch_pend_r <= 1'b0;
      inv_mask_r   <= '0;
      msg_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      fetch_pend_r <= fetch_pend_nxt;
      inv_mask_r   <= inv_mask_nxt;
      msg_cnt_r    <= msg_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fetch_dest_r <= fetch_dest_nxt;
    if (fifo_pop) begin
      cur_cmd_r  <= hd_cmd;
      cur_addr_r <= hd_addr;
      cur_home_r <= hd_home;
      cur_req_r  <= hd_req;
    end
    if (emit_fire) begin
      out_kind_r  <= em_kind;
      out_dest_r  <= 2'(em_dest);
      out_src_r   <= cur_home_r;
      out_reply_r <= cur_req_r;
      out_addr_r  <= cur_addr_r;
      out_local_r <= (em_dest == home_n);
      out_last_r  <= !em_more;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dir_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= dir_mem[hd_idx];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_msg_kind    = out_kind_r;
  assign out_dest_node   = out_dest_r;
  assign out_source_node = out_src_r;
  assign out_reply_node  = out_reply_r;
  assign out_msg_addr    = out_addr_r;
  assign out_is_local    = out_local_r;
  assign out_last        = out_last_r;

endmodule

@@ src/directory_coherence_controller_top.sv @@
// In the directory sequencer a request has its entry read, then is planned and written back,
// then sends its messages (0 to 4), one per cycle unless out_stall holds the output stage.
// The first message passes the intake register, the queue, the read, plan and emit steps.
// After reset the directory, 2^(clog2(NODES)+ADDR_BITS) entries (4096 by default), is cleared
// one entry per cycle; in_stall stays high for that sweep.
// ----------------------------------------------------------------------------
// directory_coherence_controller_top: MSI directory controller
// Intake stage and request queue in front of a directory sequencer that
// sends fetch and invalidate messages and keeps per line state and sharers.
// ----------------------------------------------------------------------------
module directory_coherence_controller_top #(
  parameter int NODES       = 4,
  parameter int ADDR_BITS   = 10,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_command,
  input  logic [ADDR_BITS-1:0] in_line_addr,
  input  logic [1:0]           in_home_node,
  input  logic [1:0]           in_requester,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_msg_kind,
  output logic [1:0]           out_dest_node,
  output logic [1:0]           out_source_node,
  output logic [1:0]           out_reply_node,
  output logic [ADDR_BITS-1:0] out_msg_addr,
  output logic                 out_is_local,
  output logic                 out_last
);
  import dcc_pkg::*;

  localparam int REQ_W = ADDR_BITS + 5;

  fifo_stat_t       fifo_stat;
  logic             push;
  logic [REQ_W-1:0] push_data;
  logic             pop;
  logic [REQ_W-1:0] head;
  logic             clr_busy;

  dcc_front #(
    .NODES     (NODES),
    .ADDR_BITS (ADDR_BITS),
    .REQ_W     (REQ_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_line_addr (in_line_addr),
    .in_home_node (in_home_node),
    .in_requester (in_requester),
    .clr_busy     (clr_busy),
    .fifo_stat    (fifo_stat),
    .push         (push),
    .push_data    (push_data)
  );

  dcc_fifo #(
    .WIDTH (REQ_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (head),
    .stat      (fifo_stat)
  );

  dcc_back #(
    .NODES     (NODES),
    .ADDR_BITS (ADDR_BITS),
    .REQ_W     (REQ_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .fifo_stat       (fifo_stat),
    .fifo_head       (head),
    .fifo_pop        (pop),
    .clr_busy        (clr_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_msg_kind    (out_msg_kind),
    .out_dest_node   (out_dest_node),
    .out_source_node (out_source_node),
    .out_reply_node  (out_reply_node),
    .out_msg_addr    (out_msg_addr),
    .out_is_local    (out_is_local),
    .out_last        (out_last)
  );

endmodule
